// ===== rtl/dmsl_pkg.sv =====
// Shared constants, types and codes for the depth map store.
// No dependencies; every other file imports this package.
package dmsl_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

    // clamped size, column, row and store address widths
    localparam int SIZE_W  = $clog2(MAX_DIM + 1);
    localparam int XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int PROD_W  = YW + SIZE_W + 1;

    // field widths
    localparam int COORD_W = 16;
    localparam int CHAN_W  = 8;
    localparam int DEPTH_W = 7;
    localparam int LEVEL_W = 8;
    localparam int DIMCFG_W = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    // remainder unit: bits retired per cycle
    localparam int WRAP_BITS  = 2;
    localparam int WRAP_STEPS = COORD_W / WRAP_BITS;
    localparam int CNT_W      = (WRAP_STEPS > 1) ? $clog2(WRAP_STEPS) : 1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_BYTE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_LEVEL  = 3'd4;

    // pixel formats
    localparam logic [1:0] FMT_GRAY       = 2'd0;
    localparam logic [1:0] FMT_GRAY_ALPHA = 2'd1;
    localparam logic [1:0] FMT_RGB        = 2'd2;
    localparam logic [1:0] FMT_RGBA       = 2'd3;

    // request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP_X,
        ST_WRAP_Y,
        ST_ADDR,
        ST_ACCESS,
        ST_RESP
    } state_t;

    // result of the shared remainder unit
    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] value;
    } wrap_res_t;

endpackage

// ===== rtl/dmsl_if.sv =====
// Handshake channels of the depth map store: request, response, config.
// Depends on dmsl_pkg.
interface dmsl_req_if import dmsl_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [CHAN_W-1:0]         chan_a;
    logic [CHAN_W-1:0]         chan_b;
    logic [CHAN_W-1:0]         chan_c;
    logic [CHAN_W-1:0]         chan_d;

    modport source (output valid, req_type, coord_x, coord_y, chan_a, chan_b, chan_c, chan_d,
                    input ready);
    modport sink (input valid, req_type, coord_x, coord_y, chan_a, chan_b, chan_c, chan_d,
                  output ready);
endinterface

interface dmsl_rsp_if import dmsl_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic [DEPTH_W-1:0]        depth_out;
    logic signed [LEVEL_W-1:0] level_out;

    modport source (output valid, depth_out, level_out, input ready);
    modport sink (input valid, depth_out, level_out, output ready);
endinterface

interface dmsl_cfg_if import dmsl_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/dmsl_wrap_unit.sv =====
// Shared remainder unit: wraps a signed 16-bit coordinate into 0..size-1.
// Depends on dmsl_pkg. Retires WRAP_BITS dividend bits per cycle.
module dmsl_wrap_unit
    import dmsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COORD_W-1:0] raw,
    input  logic [SIZE_W-1:0]  size,
    output wrap_res_t          res
);

    logic [COORD_W-1:0] mag_reg;
    logic [SIZE_W-1:0]  rem_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [SIZE_W-1:0]  value_reg;

    logic [COORD_W-1:0] mag_next;
    logic [SIZE_W-1:0]  rem_next;
    logic [SIZE_W-1:0]  fixed;

    // restoring remainder steps on the magnitude
    always_comb
    begin
        logic [SIZE_W:0] t;
        rem_next = rem_reg;
        mag_next = mag_reg;
        t = '0;
        for (int i = 0; i < WRAP_BITS; i++)
        begin
            t = {rem_next, mag_next[COORD_W-1]};
            mag_next = {mag_next[COORD_W-2:0], 1'b0};
            if (t >= {1'b0, size})
            begin
                t = t - {1'b0, size};
            end
            rem_next = t[SIZE_W-1:0];
        end
        // negative side: map a nonzero remainder to size minus it
        fixed = (neg_reg && rem_next != '0) ? size - rem_next : rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WRAP_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= raw[COORD_W-1];
            mag_reg <= raw[COORD_W-1] ? (COORD_W'(0) - raw) : raw;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
            if (cnt_reg == CNT_W'(WRAP_STEPS - 1))
            begin
                value_reg <= fixed;
            end
        end
    end

    assign res.done  = done_reg;
    assign res.value = value_reg;

endmodule

// ===== rtl/depth_map_store_with_wrap_lookup_top.sv =====
// Top level of the depth map store: config registers, sequencer, pixel
// conversion and the depth memory. Depends on dmsl_pkg, dmsl_if, dmsl_wrap_unit.
//
// One request at a time. Both coordinates go through one shared remainder
// unit that retires two bits per cycle, x first and then y. Each coordinate
// takes eight remainder steps, then the result is handed over through the
// unit's registered done flag. After that, the ST_ADDR state forms the
// row-times-width address and ST_ACCESS accesses the memory. The input
// stays not ready from a request's accept until the sequencer is back in
// idle, so no new request is accepted while one is in progress. A read
// returns to idle in the same cycle that its response beat shows. If the
// previous response beat is still waiting, the read holds until that beat
// is taken. A finished response waits in an output register, so the next
// request is accepted while it is still pending. The store needs no clearing
// after reset: reading a never-written location returns an unspecified depth.
module depth_map_store_with_wrap_lookup_top
    import dmsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dmsl_cfg_if.sink   cfg,
    dmsl_req_if.sink   req,
    dmsl_rsp_if.source rsp
);

    // configuration
    logic [1:0]          pixel_format_reg;
    logic [DIMCFG_W-1:0] image_width_reg;
    logic [DIMCFG_W-1:0] image_height_reg;
    logic [CHAN_W-1:0]   focal_byte_reg;
    logic [DEPTH_W-1:0]  focal_level_reg;

    state_t state_reg;
    state_t state_next;

    // latched request
    logic               type_reg;
    logic [COORD_W-1:0] coord_y_reg;
    logic [CHAN_W-1:0]  chan_a_reg;
    logic [CHAN_W-1:0]  chan_b_reg;
    logic [CHAN_W-1:0]  chan_c_reg;
    logic [CHAN_W-1:0]  chan_d_reg;

    logic [XW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;

    // conversion pipeline
    logic [CHAN_W-1:0]  src_reg;
    logic [CHAN_W-1:0]  alpha_reg;
    logic [CHAN_W-1:0]  src2_reg;
    logic [15:0]        blend_reg;
    logic [DEPTH_W-1:0] depth_wr_reg;
    logic [9:0]         chan_sum;
    logic [19:0]        mean_prod;
    logic [16:0]        div255;

    logic [DEPTH_W-1:0] mem [MEM_DEPTH];
    logic [DEPTH_W-1:0] rdata_reg;

    logic                out_valid_reg;
    logic [DEPTH_W-1:0]  depth_out_reg;
    logic [LEVEL_W-1:0]  level_out_reg;

    logic [SIZE_W-1:0]  w_size;
    logic [SIZE_W-1:0]  h_size;

    logic               unit_start;
    logic [COORD_W-1:0] unit_raw;
    logic [SIZE_W-1:0]  unit_size;
    wrap_res_t          wrap_res;
    logic               out_load;
    logic               in_take;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [DIMCFG_W-1:0] v,
                                                     input int maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (int'(v) > maxv)
        begin
            r = SIZE_W'(maxv);
        end
        else
        begin
            r = SIZE_W'(v);
        end
        return r;
    endfunction

    assign w_size = clamp_size(image_width_reg, MAX_WIDTH);
    assign h_size = clamp_size(image_height_reg, MAX_HEIGHT);

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= FMT_GRAY;
            image_width_reg  <= DIMCFG_W'(512);
            image_height_reg <= DIMCFG_W'(512);
            focal_byte_reg   <= '0;
            focal_level_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg.data[1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg.data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg.data;
                REG_FOCAL_BYTE:   focal_byte_reg   <= cfg.data[CHAN_W-1:0];
                REG_FOCAL_LEVEL:  focal_level_reg  <= cfg.data[DEPTH_W-1:0];
                default:          ;
            endcase
        end
    end

    // shared remainder unit, x first then y
    dmsl_wrap_unit u_wrap
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .raw   (unit_raw),
        .size  (unit_size),
        .res   (wrap_res)
    );

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_WRAP_X;
                end
            end
            ST_WRAP_X:
            begin
                if (wrap_res.done)
                begin
                    state_next = ST_WRAP_Y;
                end
            end
            ST_WRAP_Y:
            begin
                if (wrap_res.done)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                state_next = (type_reg == REQ_READ) ? ST_RESP : ST_IDLE;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        in_take    = (state_reg == ST_IDLE) && req.valid;
        unit_start = in_take || ((state_reg == ST_WRAP_X) && wrap_res.done);
        unit_raw   = (state_reg == ST_IDLE) ? req.coord_x : coord_y_reg;
        // hold the width for the whole x pass, the height only while y runs
        unit_size  = (state_reg == ST_WRAP_Y) ? h_size : w_size;
        out_load   = (state_reg == ST_RESP) && (!out_valid_reg || rsp.ready);
    end

    assign req.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            type_reg    <= req.req_type;
            coord_y_reg <= req.coord_y;
            chan_a_reg  <= req.chan_a;
            chan_b_reg  <= req.chan_b;
            chan_c_reg  <= req.chan_c;
            chan_d_reg  <= req.chan_d;
        end
        if ((state_reg == ST_WRAP_X) && wrap_res.done)
        begin
            x_reg <= XW'(wrap_res.value);
        end
        if ((state_reg == ST_WRAP_Y) && wrap_res.done)
        begin
            y_reg <= YW'(wrap_res.value);
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= addr_next;
        end
    end

    assign addr_next = ADDR_W'(PROD_W'(y_reg) * PROD_W'(w_size) + PROD_W'(x_reg));

    // pixel conversion; registered stages that settle long before the write
    always_comb
    begin
        chan_sum  = 10'(chan_a_reg) + 10'(chan_b_reg) + 10'(chan_c_reg);
        // divide by 3: multiply by 683 / 2048, exact for sums up to 765
        mean_prod = 20'(chan_sum) * 20'd683;
        // divide by 255, exact for values up to 255 * 255, which covers every blend
        div255    = (17'(blend_reg) + 17'(blend_reg[15:8]) + 17'd1) >> 8;
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= (pixel_format_reg == FMT_GRAY || pixel_format_reg == FMT_GRAY_ALPHA)
                     ? chan_a_reg : mean_prod[18:11];
        alpha_reg <= (pixel_format_reg == FMT_GRAY_ALPHA) ? chan_b_reg : chan_d_reg;
        src2_reg  <= src_reg;
        blend_reg <= 16'(src_reg) * 16'(alpha_reg)
                     + 16'(focal_byte_reg) * 16'(8'd255 - alpha_reg);
        if (pixel_format_reg == FMT_GRAY_ALPHA || pixel_format_reg == FMT_RGBA)
        begin
            depth_wr_reg <= div255[7:1];
        end
        else
        begin
            depth_wr_reg <= src2_reg[7:1];
        end
    end

    // depth store
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACCESS)
        begin
            if (type_reg == REQ_WRITE)
            begin
                mem[addr_reg] <= depth_wr_reg;
            end
            else
            begin
                rdata_reg <= mem[addr_reg];
            end
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            depth_out_reg <= rdata_reg;
            level_out_reg <= LEVEL_W'(rdata_reg) - LEVEL_W'(focal_level_reg);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.depth_out = depth_out_reg;
    assign rsp.level_out = level_out_reg;

    // the remainder unit only reports while the sequencer waits for it
    a_done_in_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        wrap_res.done |-> (state_reg == ST_WRAP_X || state_reg == ST_WRAP_Y))
        else $error("wrap unit done outside a wrap state");

    // wrapped coordinates lie inside the image
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADDR) |-> (SIZE_W'(x_reg) < w_size && SIZE_W'(y_reg) < h_size))
        else $error("wrapped coordinate out of range");

    // a response beat only appears after a read reached the response state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RESP && type_reg == REQ_READ))
        else $error("response without a read");

    // the store is addressed only with a location inside the map
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCESS) |-> (int'(addr_reg) < int'(w_size) * int'(h_size)))
        else $error("store address outside the map");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for depth_map_store_with_wrap_lookup_top: directed rows, then randomized
// phases checked against a local depth map predictor. Depends on dmsl_pkg and dmsl_if.
module tb_top;
    import dmsl_pkg::*;

    localparam int NUM_PHASES   = 8;
    localparam int QUIET_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [CHAN_W-1:0]         a;
        logic [CHAN_W-1:0]         b;
        logic [CHAN_W-1:0]         c;
        logic [CHAN_W-1:0]         d;
    } req_beat_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]        depth;
        logic signed [LEVEL_W-1:0] level;
    } rsp_beat_t;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        req_beat_t             beat;
        logic                  typed;
        rsp_beat_t             known;
    } stim_row_t;

    typedef struct packed {
        logic [1:0]          fmt;
        logic [DIMCFG_W-1:0] width;
        logic [DIMCFG_W-1:0] height;
        logic [7:0]          fbyte;
        logic [6:0]          flevel;
        logic [7:0]          send_pct;
        logic [7:0]          recv_pct;
        logic [7:0]          read_pct;
        logic [15:0]         hold;
        logic [15:0]         items;
    } phase_t;

    logic clk = 1'b0;
    logic rst_n;

    dmsl_cfg_if cfg_bus();
    dmsl_req_if req_bus();
    dmsl_rsp_if rsp_bus();

    depth_map_store_with_wrap_lookup_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #2 clk = ~clk;

    // shadow registers and depth map of the predictor
    logic [1:0]          fmt_reg;
    logic [DIMCFG_W-1:0] width_reg;
    logic [DIMCFG_W-1:0] height_reg;
    logic [7:0]          focal_byte_reg;
    logic [6:0]          focal_level_reg;
    logic [DEPTH_W-1:0]  shadow_store [int];
    int                  stored_addrs [$];

    rsp_beat_t depth_results_due [$];
    stim_row_t directed_rows [$];
    phase_t    phases [NUM_PHASES];

    int errors        = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request  = 0;
    int cycle_count;

    function automatic int dim_eff(logic [DIMCFG_W-1:0] raw, int max_dim);
        if (raw == 0)
            return 1;
        return (int'(raw) > max_dim) ? max_dim : int'(raw);
    endfunction

    // true modulo of a signed coordinate
    function automatic int wrap_pos(logic signed [COORD_W-1:0] coord, int size);
        int mag;
        int r;
        if (coord < 0)
        begin
            mag = -int'(coord);
            r = mag % size;
            return (r == 0) ? 0 : size - r;
        end
        return int'(coord) % size;
    endfunction

    // pick a random coordinate in 16-bit range that wraps to pos
    function automatic logic signed [COORD_W-1:0] alias_coord(int pos, int size);
        int kmin;
        int kmax;
        kmin = -((32768 + pos) / size);
        kmax = (32767 - pos) / size;
        return COORD_W'(pos + size * (kmin + int'($urandom_range(kmax - kmin))));
    endfunction

    // apply one request to the depth map; returns 1 when a lookup result is due
    function automatic bit map_access(req_beat_t bt, output rsp_beat_t res);
        int w;
        int h;
        int addr;
        int mean;
        int blended;
        logic [DEPTH_W-1:0] stored;
        w = dim_eff(width_reg, MAX_WIDTH);
        h = dim_eff(height_reg, MAX_HEIGHT);
        addr = wrap_pos(bt.y, h) * w + wrap_pos(bt.x, w);
        res = '0;
        if (bt.kind == REQ_WRITE)
        begin
            mean = (int'(bt.a) + int'(bt.b) + int'(bt.c)) / 3;
            case (fmt_reg)
                FMT_GRAY:       blended = int'(bt.a);
                FMT_GRAY_ALPHA: blended = (int'(bt.a) * int'(bt.b)
                                           + int'(focal_byte_reg) * (255 - int'(bt.b))) / 255;
                FMT_RGB:        blended = mean;
                default:        blended = (mean * int'(bt.d)
                                           + int'(focal_byte_reg) * (255 - int'(bt.d))) / 255;
            endcase
            if (!shadow_store.exists(addr))
                stored_addrs.push_back(addr);
            shadow_store[addr] = DEPTH_W'(blended / 2);
            return 1'b0;
        end
        stored = shadow_store.exists(addr) ? shadow_store[addr] : '0;
        res.depth = stored;
        res.level = LEVEL_W'(int'(stored) - int'(focal_level_reg));
        return 1'b1;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_ADDR_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic stim_row_t beat_row(logic kind, int x, int y, int a, int b, int c,
                                           int d, bit typed, int depth, int level);
        stim_row_t row;
        row = '0;
        row.beat = '{kind, COORD_W'(x), COORD_W'(y), CHAN_W'(a), CHAN_W'(b), CHAN_W'(c),
                     CHAN_W'(d)};
        row.typed = typed;
        row.known = '{DEPTH_W'(depth), LEVEL_W'(level)};
        return row;
    endfunction

    // drain outstanding lookups, then let a trailing write finish
    task automatic wait_quiet();
        req_bus.valid <= 1'b0;
        while (depth_results_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val,
                             bit last);
        cfg_bus.valid <= 1'b1;
        cfg_bus.addr  <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            REG_PIXEL_FORMAT: fmt_reg = val[1:0];
            REG_IMAGE_WIDTH:  width_reg = val[DIMCFG_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = val[DIMCFG_W-1:0];
            REG_FOCAL_BYTE:   focal_byte_reg = val[7:0];
            REG_FOCAL_LEVEL:  focal_level_reg = val[6:0];
            default: ;
        endcase
        // a new size lays the map out again: forget what was written
        if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT)
        begin
            shadow_store.delete();
            stored_addrs.delete();
        end
        if (last)
            cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_beat(req_beat_t bt, bit typed, rsp_beat_t known);
        rsp_beat_t due;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= bt.kind;
        req_bus.coord_x  <= bt.x;
        req_bus.coord_y  <= bt.y;
        req_bus.chan_a   <= bt.a;
        req_bus.chan_b   <= bt.b;
        req_bus.chan_c   <= bt.c;
        req_bus.chan_d   <= bt.d;
        do @(posedge clk); while (!req_bus.ready);
        sent_count++;
        if (map_access(bt, due))
            depth_results_due.push_back(typed ? known : due);
    endtask

    // response side: check each beat, stall at random, honor long holds
    initial
    begin
        rsp_beat_t want;
        int hold_left;
        hold_left = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (depth_results_due.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected response beat: depth %0d level %0d", $time,
                             rsp_bus.depth_out, rsp_bus.level_out);
                end
                else
                begin
                    want = depth_results_due.pop_front();
                    checked_count++;
                    if (rsp_bus.depth_out !== want.depth)
                    begin
                        errors++;
                        $display("%0t depth_out mismatch: expected %0d, actual %0d", $time,
                                 want.depth, rsp_bus.depth_out);
                    end
                    if (rsp_bus.level_out !== want.level)
                    begin
                        errors++;
                        $display("%0t level_out mismatch: expected %0d, actual %0d", $time,
                                 want.level, rsp_bus.level_out);
                    end
                end
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        req_beat_t bt;
        phase_t    ph;
        int        i;
        int        n;
        int        w;
        int        h;
        int        addr;
        int        pick;

        rst_n            <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.addr     <= '0;
        cfg_bus.data     <= '0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_WRITE;
        req_bus.coord_x  <= '0;
        req_bus.coord_y  <= '0;
        req_bus.chan_a   <= '0;
        req_bus.chan_b   <= '0;
        req_bus.chan_c   <= '0;
        req_bus.chan_d   <= '0;

        fmt_reg         = FMT_GRAY;
        width_reg       = DIMCFG_W'(MAX_WIDTH);
        height_reg      = DIMCFG_W'(MAX_HEIGHT);
        focal_byte_reg  = '0;
        focal_level_reg = '0;

        directed_rows = '{
            // reset settings: gray, 512 x 512, both focal values zero
            beat_row(REQ_WRITE, 0, 0, 255, 0, 0, 0, 0, 0, 0),
            beat_row(REQ_READ, 0, 0, 0, 0, 0, 0, 1, 127, 127),
            // negative multiples of the size land on zero
            beat_row(REQ_WRITE, -512, -32768, 200, 0, 0, 0, 0, 0, 0),
            beat_row(REQ_READ, 0, 0, 0, 0, 0, 0, 1, 100, 100),
            beat_row(REQ_WRITE, 32767, -1, 1, 255, 255, 255, 0, 0, 0),
            beat_row(REQ_READ, -1, -1, 0, 0, 0, 0, 1, 0, 0),
            reg_row(REG_FOCAL_LEVEL, 127),
            beat_row(REQ_READ, 511, 511, 0, 0, 0, 0, 1, 0, -127),
            beat_row(REQ_READ, 0, 0, 0, 0, 0, 0, 1, 100, -27),
            reg_row(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_GRAY_ALPHA)),
            reg_row(REG_FOCAL_BYTE, 255),
            // fully transparent: focal byte shows through, unused channels ignored
            beat_row(REQ_WRITE, 1, 0, 0, 0, 255, 255, 0, 0, 0),
            beat_row(REQ_READ, 1, 0, 0, 0, 0, 0, 1, 127, 0),
            beat_row(REQ_WRITE, 2, 0, 100, 200, 0, 0, 0, 0, 0),
            beat_row(REQ_READ, 2, -512, 0, 0, 0, 0, 0, 0, 0),
            reg_row(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_RGB)),
            beat_row(REQ_WRITE, 3, 0, 255, 255, 255, 0, 0, 0, 0),
            beat_row(REQ_READ, 3, 0, 0, 0, 0, 0, 1, 127, 0),
            reg_row(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_RGBA)),
            reg_row(REG_FOCAL_BYTE, 0),
            beat_row(REQ_WRITE, 4, 0, 255, 255, 255, 0, 0, 0, 0),
            beat_row(REQ_READ, 4, 0, 0, 0, 0, 0, 1, 0, -127),
            beat_row(REQ_WRITE, 5, 0, 10, 20, 30, 128, 0, 0, 0),
            beat_row(REQ_READ, 517, 0, 0, 0, 0, 0, 0, 0, 0),
            // width zero acts as one, height above the maximum is clamped
            reg_row(REG_IMAGE_WIDTH, 0),
            reg_row(REG_IMAGE_HEIGHT, 1023),
            beat_row(REQ_WRITE, 12345, -7, 90, 90, 90, 255, 0, 0, 0),
            beat_row(REQ_READ, -3, 505, 0, 0, 0, 0, 0, 0, 0),
            reg_row(REG_IMAGE_WIDTH, 3),
            reg_row(REG_IMAGE_HEIGHT, 0),
            beat_row(REQ_WRITE, -32768, 32767, 255, 0, 0, 255, 0, 0, 0),
            beat_row(REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0)
        };

        phases[0] = '{FMT_RGBA, 512, 512, 255, 127, 0, 0, 50, 0, 85};
        phases[1] = '{FMT_GRAY_ALPHA, 1, 1, 0, 0, 50, 0, 50, 0, 85};
        phases[2] = '{FMT_RGB, 7, 13, 128, 64, 0, 50, 50, 0, 85};
        phases[3] = '{FMT_GRAY, 1023, 0, 37, 127, 32, 32, 50, 0, 85};
        phases[4] = '{2'($urandom_range(3)), 10'($urandom_range(1023)),
                      10'($urandom_range(1023)), 8'($urandom), 7'($urandom), 50, 0, 50, 0, 85};
        phases[5] = '{FMT_RGBA, 100, 3, 200, 5, 0, 0, 80, 600, 85};
        phases[6] = '{2'($urandom_range(3)), 10'($urandom_range(1023)),
                      10'($urandom_range(1023)), 8'($urandom), 7'($urandom), 0, 50, 50, 0, 85};
        phases[7] = '{2'($urandom_range(3)), 10'($urandom_range(64)),
                      10'($urandom_range(64)), 8'($urandom), 7'($urandom), 32, 32, 50, 0, 85};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < directed_rows.size(); i++)
        begin
            if (directed_rows[i].is_reg)
            begin
                if (i == 0 || !directed_rows[i-1].is_reg)
                    wait_quiet();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val,
                          i + 1 == directed_rows.size() || !directed_rows[i+1].is_reg);
            end
            else
                send_beat(directed_rows[i].beat, directed_rows[i].typed,
                          directed_rows[i].known);
        end

        for (i = 0; i < NUM_PHASES; i++)
        begin
            ph = phases[i];
            wait_quiet();
            write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(ph.fmt), 1'b0);
            write_reg(REG_IMAGE_WIDTH, ph.width, 1'b0);
            write_reg(REG_IMAGE_HEIGHT, ph.height, 1'b0);
            write_reg(REG_FOCAL_BYTE, CFG_DATA_W'(ph.fbyte), 1'b0);
            write_reg(REG_FOCAL_LEVEL, CFG_DATA_W'(ph.flevel), 1'b1);
            send_idle_pct  = ph.send_pct;
            recv_stall_pct = ph.recv_pct;
            // hold the output off while lookups keep coming, so the input backs up
            hold_request   = ph.hold;
            w = dim_eff(width_reg, MAX_WIDTH);
            h = dim_eff(height_reg, MAX_HEIGHT);
            for (n = 0; n < ph.items; n++)
            begin
                bt.a = CHAN_W'($urandom);
                bt.b = CHAN_W'($urandom);
                bt.c = CHAN_W'($urandom);
                bt.d = CHAN_W'($urandom);
                if (stored_addrs.size() != 0 && $urandom_range(99) < ph.read_pct)
                begin
                    bt.kind = REQ_READ;
                    addr = stored_addrs[$urandom_range(stored_addrs.size() - 1)];
                    bt.x = alias_coord(addr % w, w);
                    bt.y = alias_coord(addr / w, h);
                end
                else
                begin
                    bt.kind = REQ_WRITE;
                    pick = $urandom_range(9);
                    if (pick >= 7 && stored_addrs.size() != 0)
                    begin
                        // overwrite a known entry through another alias
                        addr = stored_addrs[$urandom_range(stored_addrs.size() - 1)];
                        bt.x = alias_coord(addr % w, w);
                        bt.y = alias_coord(addr / w, h);
                    end
                    else if (pick >= 4)
                    begin
                        bt.x = COORD_W'($urandom_range(w - 1));
                        bt.y = COORD_W'($urandom_range(h - 1));
                    end
                    else
                    begin
                        bt.x = COORD_W'($urandom);
                        bt.y = COORD_W'($urandom);
                    end
                end
                send_beat(bt, 1'b0, '0);
            end
        end

        req_bus.valid <= 1'b0;
        while (depth_results_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);

        $display("%0d request beats sent, %0d lookups checked, over %0d register settings",
                 sent_count, checked_count, NUM_PHASES + 1);
        $display("with sender gaps, response stalls and one long output hold");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
